@@ hdl/tks_pkg.sv @@
// Shared types and constants for the top-k score selector.
// Holds the word types of both channels and the control word that drives each cell.
// No dependencies; every other file imports this package.
`default_nettype none

package tks_pkg;

  // Fixed field widths of the channel words.
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned OUT_IDX_W  = 10;
  localparam int unsigned RANK_W     = 3;
  localparam int unsigned CFG_W      = 4;

  // At most this many entries are reported for one image.
  localparam int unsigned RESULT_CAP = 8;
  localparam int unsigned REM_W      = $clog2(RESULT_CAP + 1);

  // Reset value of the top_count register.
  localparam logic [CFG_W-1:0] TOP_COUNT_RST = 4'd5;

  // Input word: one class score.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;
  } in_word_t;

  // Result word: one reported entry.
  typedef struct packed {
    logic [OUT_IDX_W-1:0]      class_index;
    logic signed [SCORE_W-1:0] class_score;
    logic [RANK_W-1:0]         rank;
    logic                      last_result;
  } out_word_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the incoming score into the sorted list
    logic clr;    // empty the sorted list after this cycle
    logic load;   // copy the updated list into the report slots
    logic shift;  // move the report slots one place toward the output
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/tks_cell.sv @@
// One cell of the sorted chain: a kept entry plus one report slot.
// Depends on tks_pkg for the control word and field widths.
`default_nettype none

module tks_cell
  import tks_pkg::*;
#(
  parameter int unsigned IDX_W = 10
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire cell_ctrl_t           ctrl,
  input  wire signed [SCORE_W-1:0]  new_score,
  input  wire        [IDX_W-1:0]    new_index,
  input  wire                       prev_valid,
  input  wire signed [SCORE_W-1:0]  prev_score,
  input  wire        [IDX_W-1:0]    prev_index,
  input  wire                       prev_beat,
  input  wire signed [SCORE_W-1:0]  drain_in_score,
  input  wire        [IDX_W-1:0]    drain_in_index,
  output logic                      beat,
  output logic                      valid_o,
  output logic signed [SCORE_W-1:0] score_o,
  output logic        [IDX_W-1:0]   index_o,
  output logic signed [SCORE_W-1:0] drain_score,
  output logic        [IDX_W-1:0]   drain_index
);

  logic                      valid_r, valid_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic        [IDX_W-1:0]   index_r, index_nxt;
  logic signed [SCORE_W-1:0] dscore_r, dscore_nxt;
  logic        [IDX_W-1:0]   dindex_r, dindex_nxt;

  // The new score beats this entry if the slot is empty or the score is
  // strictly higher, so equal scores keep the earlier index in front.
  assign beat = !valid_r || (new_score > score_r);

  // Insertion: the first beaten cell takes the new score, every beaten cell
  // behind it takes its left neighbor's entry.
  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    index_nxt = index_r;
    if (ctrl.ins && beat) begin
      if (prev_beat) begin
        valid_nxt = prev_valid;
        score_nxt = prev_score;
        index_nxt = prev_index;
      end else begin
        valid_nxt = 1'b1;
        score_nxt = new_score;
        index_nxt = new_index;
      end
    end
  end

  // Report slot: loads the updated entry at the end of an image, then
  // shifts toward the output as words are taken.
  always_comb begin
    dscore_nxt = dscore_r;
    dindex_nxt = dindex_r;
    if (ctrl.load) begin
      dscore_nxt = score_nxt;
      dindex_nxt = index_nxt;
    end else if (ctrl.shift) begin
      dscore_nxt = drain_in_score;
      dindex_nxt = drain_in_index;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clr) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    score_r  <= score_nxt;
    index_r  <= index_nxt;
    dscore_r <= dscore_nxt;
    dindex_r <= dindex_nxt;
  end

  assign valid_o     = valid_r;
  assign score_o     = score_r;
  assign index_o     = index_r;
  assign drain_score = dscore_r;
  assign drain_index = dindex_r;

endmodule

`default_nettype wire

@@ hdl/top_k_score_selector.sv @@
// Top level of the top-k score selector: chain of tks_cell, counters and ports.
// Depends on tks_pkg and tks_cell.
`default_nettype none

// Streaming top-k selector. Class scores enter one word per cycle; each word
// is inserted into a chain of TOP_MAX cells that keeps the best scores sorted,
// ties going to the earlier class. When the word marked last_score is taken,
// the updated list is copied into the report slots of the same cells and the
// list is cleared, so the next image streams in at once. The report comes
// out one word per cycle while out_ready is high, best first, with the final word
// flagged: min(top_count clamped to 1..LIM, entries kept) words. A last_score
// word waits (in_ready low) only while the previous image's report has more
// than one word to go, or one not taken. Scores past MAX_CLASSES in one image
// are dropped; top_count may only be written while the block is idle.
module top_k_score_selector
  import tks_pkg::*;
#(
  parameter int unsigned TOP_MAX     = 8,
  parameter int unsigned MAX_CLASSES = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire in_word_t     in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output out_word_t         out_data,
  input  wire               cfg_we,
  input  wire [CFG_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
  localparam int unsigned POS_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned CNT_W = $clog2(TOP_MAX + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned LIM   = (TOP_MAX < RESULT_CAP) ? TOP_MAX : RESULT_CAP;

  logic [CFG_W-1:0]  top_count_r;
  logic [POS_W-1:0]  position_r, position_nxt;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [REM_W-1:0]  remaining_r, remaining_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  logic       in_acc, out_acc, pos_ok, drain_free;
  cell_ctrl_t ctrl;

  logic [CMP_W-1:0] tc_w, want_w, filled_w, n_w;

  // Chain wiring: element i carries cell i's outputs.
  logic                      beat_v  [TOP_MAX];
  logic                      valid_v [TOP_MAX];
  logic signed [SCORE_W-1:0] score_v [TOP_MAX];
  logic        [IDX_W-1:0]   index_v [TOP_MAX];
  logic signed [SCORE_W-1:0] dscore_v[TOP_MAX];
  logic        [IDX_W-1:0]   dindex_v[TOP_MAX];
  logic        [TOP_MAX-1:0] valid_vec;

  // Handshake: a last word needs the report slots free by the next edge.
  assign drain_free = (remaining_r == '0) ||
                      ((remaining_r == REM_W'(1)) && out_ready);
  assign in_ready   = !in_data.last_score || drain_free;
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign pos_ok     = position_r < POS_W'(MAX_CLASSES);

  assign ctrl.ins   = in_acc && pos_ok;
  assign ctrl.clr   = in_acc && in_data.last_score;
  assign ctrl.load  = in_acc && in_data.last_score;
  assign ctrl.shift = out_acc;

  // The cell chain.
  for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
    logic                      pv, pb;
    logic signed [SCORE_W-1:0] ps, ds;
    logic        [IDX_W-1:0]   pi, di;

    if (i == 0) begin : g_head
      assign pv = 1'b0;
      assign ps = '0;
      assign pi = '0;
      assign pb = 1'b0;
    end else begin : g_body
      assign pv = valid_v[i-1];
      assign ps = score_v[i-1];
      assign pi = index_v[i-1];
      assign pb = beat_v[i-1];
    end

    if (i == TOP_MAX - 1) begin : g_tail
      assign ds = '0;
      assign di = '0;
    end else begin : g_mid
      assign ds = dscore_v[i+1];
      assign di = dindex_v[i+1];
    end

    tks_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .new_score     (in_data.score),
      .new_index     (position_r[IDX_W-1:0]),
      .prev_valid    (pv),
      .prev_score    (ps),
      .prev_index    (pi),
      .prev_beat     (pb),
      .drain_in_score(ds),
      .drain_in_index(di),
      .beat          (beat_v[i]),
      .valid_o       (valid_v[i]),
      .score_o       (score_v[i]),
      .index_o       (index_v[i]),
      .drain_score   (dscore_v[i]),
      .drain_index   (dindex_v[i])
    );

    assign valid_vec[i] = valid_v[i];
  end

  // Entry count and class position of the image in progress.
  always_comb begin
    filled_nxt   = filled_r;
    position_nxt = position_r;
    if (ctrl.ins) begin
      position_nxt = position_r + POS_W'(1);
      if (filled_r != CNT_W'(TOP_MAX)) begin
        filled_nxt = filled_r + CNT_W'(1);
      end
    end
  end

  // Number of words to report: top_count clamped, then limited by entries.
  always_comb begin
    tc_w     = CMP_W'(top_count_r);
    filled_w = CMP_W'(filled_nxt);
    if (tc_w == '0) begin
      want_w = CMP_W'(1);
    end else if (tc_w > CMP_W'(LIM)) begin
      want_w = CMP_W'(LIM);
    end else begin
      want_w = tc_w;
    end
    n_w = (filled_w < want_w) ? filled_w : want_w;
  end

  // Report counters.
  always_comb begin
    remaining_nxt = remaining_r;
    rank_nxt      = rank_r;
    if (ctrl.load) begin
      remaining_nxt = REM_W'(n_w);
      rank_nxt      = '0;
    end else if (out_acc) begin
      remaining_nxt = remaining_r - REM_W'(1);
      rank_nxt      = rank_r + RANK_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RST;
      position_r  <= '0;
      filled_r    <= '0;
      remaining_r <= '0;
      rank_r      <= '0;
    end else begin
      if (cfg_we) begin
        top_count_r <= cfg_data;
      end
      if (ctrl.clr) begin
        position_r <= '0;
        filled_r   <= '0;
      end else begin
        position_r <= position_nxt;
        filled_r   <= filled_nxt;
      end
      remaining_r <= remaining_nxt;
      rank_r      <= rank_nxt;
    end
  end

  // Result word straight from the head report slot.
  assign out_valid            = remaining_r != '0;
  assign out_data.class_index = OUT_IDX_W'(dindex_v[0]);
  assign out_data.class_score = dscore_v[0];
  assign out_data.rank        = rank_r;
  assign out_data.last_result = remaining_r == REM_W'(1);

  // The kept entries always form a prefix; their count must equal filled_r.
  a_filled_matches: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_vec)) == filled_r)
    else $error("entry count disagrees with occupied cells");

  // A taken last score starts a report at rank zero.
  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_score) |=> (out_valid && out_data.rank == '0))
    else $error("report did not start after last score");

  // After the final word, the channel is empty or a fresh report begins.
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.last_result) |=> (!out_valid || out_data.rank == '0))
    else $error("report continued past its final word");

  // The count of pending words never exceeds the reporting limit.
  a_remaining_cap: assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r <= REM_W'(LIM))
    else $error("pending word count out of range");

endmodule

`default_nettype wire
